>>> src/lsfc_pkg.sv
// Shared constants of the line sensor frame centroid core.
package lsfc_pkg;

   localparam logic [7:0] HDR_FIRST  = 8'h55;
   localparam logic [7:0] HDR_SECOND = 8'hAA;
   localparam logic [7:0] CMD_ANALOG = 8'h02;

   localparam int CNT_W = 5;   // black channel count, up to 16

   typedef logic [1:0] status_type;
   localparam status_type ST_GOOD = 2'd0;
   localparam status_type ST_BAD  = 2'd1;
   localparam status_type ST_OVER = 2'd2;

   typedef logic [2:0] csr_addr_type;
   localparam csr_addr_type CSR_THRESHOLD = 3'd0;
   localparam csr_addr_type CSR_BLACK_HI  = 3'd1;
   localparam csr_addr_type CSR_REVERSE   = 3'd2;
   localparam csr_addr_type CSR_ANALOG    = 3'd3;
   localparam csr_addr_type CSR_WEIGHTS_L = 3'd4;
   localparam csr_addr_type CSR_WEIGHTS_H = 3'd5;

   typedef struct packed {
      logic [15:0] threshold;
      logic        black_hi;
      logic        reverse;
      logic        analog;
      logic [63:0] weights_l;
      logic [63:0] weights_h;
   } cfg_type;

endpackage

>>> src/lsfc_front.sv
// Frame parser: header hunt, length check, checksum, payload capture.
module lsfc_front #(
   parameter int CHANNELS    = 8,
   parameter int MAX_PAYLOAD = 16
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        byte_valid,
   input  logic [7:0]                  byte_data,
   output logic                        job_push,
   output lsfc_pkg::status_type        job_status,
   output logic [CHANNELS*16-1:0]      job_samples
);
   import lsfc_pkg::*;

   localparam int OFF_W = $clog2(MAX_PAYLOAD + 6);
   localparam int PAY_W = CHANNELS * 16;

   logic [OFF_W-1:0] offset_ff, offset_in;
   logic [7:0]       cmd_ff, cmd_in;
   logic [7:0]       len_ff, len_in;
   logic [7:0]       sum_ff, sum_in;
   logic [PAY_W-1:0] pay_ff, pay_in;
   logic             last_byte;

   assign last_byte = ({1'b0, len_ff} + 9'd4) == 9'(offset_ff);
   assign job_samples = pay_ff;

   always_comb begin
      offset_in  = offset_ff;
      cmd_in     = cmd_ff;
      len_in     = len_ff;
      sum_in     = sum_ff;
      pay_in     = pay_ff;
      job_push   = 1'b0;
      job_status = ST_GOOD;
      if (byte_valid) begin
         if (offset_ff == '0) begin
            if (byte_data == HDR_FIRST) offset_in = OFF_W'(1);
         end else if (offset_ff == OFF_W'(1)) begin
            if (byte_data == HDR_SECOND) offset_in = OFF_W'(2);
            else if (byte_data != HDR_FIRST) offset_in = '0;
         end else if (offset_ff == OFF_W'(2)) begin
            cmd_in    = byte_data;
            sum_in    = byte_data;
            offset_in = OFF_W'(3);
         end else if (offset_ff == OFF_W'(3)) begin
            len_in = byte_data;
            sum_in = sum_ff + byte_data;
            if ({1'b0, byte_data} > 9'(MAX_PAYLOAD)) begin
               job_push   = 1'b1;
               job_status = ST_OVER;
               offset_in  = '0;
            end else begin
               offset_in = OFF_W'(4);
            end
         end else if (last_byte) begin
            // checksum byte closes the frame
            job_push  = 1'b1;
            offset_in = '0;
            if (cmd_ff == CMD_ANALOG && {1'b0, len_ff} == 9'(2 * CHANNELS) &&
                ~sum_ff == byte_data)
               job_status = ST_GOOD;
            else
               job_status = ST_BAD;
         end else begin
            sum_in    = sum_ff + byte_data;
            pay_in    = {byte_data, pay_ff[PAY_W-1:8]};
            offset_in = offset_ff + OFF_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         offset_ff <= '0;
      end else begin
         offset_ff <= offset_in;
      end
      cmd_ff <= cmd_in;
      len_ff <= len_in;
      sum_ff <= sum_in;
      pay_ff <= pay_in;
   end

endmodule

>>> src/lsfc_queue.sv
// Two-entry job queue between parser and position engine.
module lsfc_queue #(
   parameter int WIDTH = 130
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] push_data,
   output logic             full,
   input  logic             pop,
   output logic             not_empty,
   output logic [WIDTH-1:0] pop_data
);
   logic [WIDTH-1:0] mem_ff [2];
   logic             wr_ff, wr_in;
   logic             rd_ff, rd_in;
   logic [1:0]       cnt_ff, cnt_in;

   assign full      = cnt_ff == 2'd2;
   assign not_empty = cnt_ff != 2'd0;
   assign pop_data  = mem_ff[rd_ff];

   always_comb begin
      wr_in  = push ? ~wr_ff : wr_ff;
      rd_in  = pop ? ~rd_ff : rd_ff;
      cnt_in = cnt_ff + 2'(push) - 2'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= 1'b0;
         rd_ff  <= 1'b0;
         cnt_ff <= 2'd0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
      if (push) mem_ff[wr_ff] <= push_data;
   end

endmodule

>>> src/lsfc_back.sv
// Position engine: per-channel accumulate, serial divide, result register.
module lsfc_back #(
   parameter int CHANNELS = 8
) (
   input  logic                   clock,
   input  logic                   reset,
   input  lsfc_pkg::cfg_type      cfg,
   input  logic                   job_valid,
   input  lsfc_pkg::status_type   job_status,
   input  logic [CHANNELS*16-1:0] job_samples,
   output logic                   job_pop,
   output logic                   out_valid,
   input  logic                   out_ready,
   output lsfc_pkg::status_type   out_status,
   output logic [60:0]            out_data
);
   import lsfc_pkg::*;

   localparam int TOT_W = 16 + $clog2(CHANNELS);
   localparam int WS_W  = 32 + $clog2(CHANNELS);
   localparam int IDX_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
   localparam int DC_W  = $clog2(WS_W + 1);

   localparam logic [2:0] S_IDLE = 3'd0;
   localparam logic [2:0] S_ACC  = 3'd1;
   localparam logic [2:0] S_PREP = 3'd2;
   localparam logic [2:0] S_DIV  = 3'd3;
   localparam logic [2:0] S_OUT  = 3'd4;

   logic [2:0]          state_ff, state_in;
   logic [15:0]         samp_ff [CHANNELS];
   status_type          status_ff, status_in;
   logic [4:0]          k_ff, k_in;
   logic [7:0]          mask_ff, mask_in;
   logic [CNT_W-1:0]    count_ff, count_in;
   logic [TOT_W-1:0]    total_ff, total_in;
   logic [15:0]         peak_ff, peak_in;
   logic signed [31:0]  prod_ff, prod_in;
   logic signed [WS_W-1:0] wsum_ff, wsum_in;
   logic                lost_ff, lost_in;
   logic                neg_ff, neg_in;
   logic [TOT_W-1:0]    den_ff, den_in;
   logic [TOT_W:0]      rem_ff, rem_in;
   logic [WS_W-1:0]     quo_ff, quo_in;
   logic [DC_W-1:0]     dcnt_ff, dcnt_in;
   logic [15:0]         held_ff, held_in;
   logic                ovalid_ff, ovalid_in;
   status_type          ostat_ff, ostat_in;
   logic [60:0]         odata_ff, odata_in;

   logic [4:0]          phys;
   logic [15:0]         s_k;
   logic signed [15:0]  w_k;
   logic                blk;
   logic [127:0]        wall;
   logic [TOT_W-1:0]    den_c;
   logic [TOT_W:0]      trial;
   logic [15:0]         pos_abs;
   logic [15:0]         tot_sat;
   logic [15:0]         peak_o;

   assign wall = {cfg.weights_h, cfg.weights_l};

   always_comb begin
      phys = cfg.reverse ? 5'(CHANNELS - 1) - k_ff : k_ff;
      s_k  = samp_ff[phys[IDX_W-1:0]];
      w_k  = (k_ff < 5'd8) ? $signed(wall[{k_ff[2:0], 4'd0} +: 16]) : 16'sd0;
      blk  = cfg.black_hi ? (s_k > cfg.threshold) : (s_k < cfg.threshold);
      den_c = cfg.analog ? total_ff : TOT_W'(count_ff);
      trial = {rem_ff[TOT_W-1:0], quo_ff[WS_W-1]};
      pos_abs = quo_ff[15:0];
      tot_sat = ({1'b0, total_ff} > (TOT_W + 1)'(65535)) ? 16'hFFFF : 16'(total_ff);
      peak_o  = peak_ff;
   end

   always_comb begin
      state_in  = state_ff;
      status_in = status_ff;
      k_in      = k_ff;
      mask_in   = mask_ff;
      count_in  = count_ff;
      total_in  = total_ff;
      peak_in   = peak_ff;
      prod_in   = prod_ff;
      wsum_in   = wsum_ff;
      lost_in   = lost_ff;
      neg_in    = neg_ff;
      den_in    = den_ff;
      rem_in    = rem_ff;
      quo_in    = quo_ff;
      dcnt_in   = dcnt_ff;
      held_in   = held_ff;
      ovalid_in = ovalid_ff & ~out_ready;
      ostat_in  = ostat_ff;
      odata_in  = odata_ff;
      job_pop   = 1'b0;
      case (state_ff)
         S_IDLE: begin
            if (job_valid) begin
               job_pop   = 1'b1;
               status_in = job_status;
               k_in      = '0;
               mask_in   = '0;
               count_in  = '0;
               total_in  = '0;
               peak_in   = '0;
               prod_in   = '0;
               wsum_in   = '0;
               lost_in   = 1'b0;
               state_in  = (job_status == ST_GOOD) ? S_ACC : S_OUT;
            end
         end
         S_ACC: begin
            // product of channel k is registered, added in the next cycle
            if (k_ff != '0) wsum_in = wsum_ff + WS_W'(prod_ff);
            if (k_ff == 5'(CHANNELS)) begin
               state_in = S_PREP;
            end else begin
               if (blk) begin
                  if (k_ff < 5'd8) mask_in[k_ff[2:0]] = 1'b1;
                  count_in = count_ff + CNT_W'(1);
               end
               total_in = total_ff + TOT_W'(s_k);
               if (s_k > peak_ff) peak_in = s_k;
               if (cfg.analog)
                  prod_in = $signed(32'(w_k)) * $signed(32'({1'b0, s_k}));
               else
                  prod_in = blk ? 32'(w_k) : 32'sd0;
               k_in = k_ff + 5'd1;
            end
         end
         S_PREP: begin
            den_in  = den_c;
            lost_in = den_c == '0;
            neg_in  = wsum_ff < 0;
            quo_in  = (wsum_ff < 0) ? WS_W'(-wsum_ff) : WS_W'(wsum_ff);
            rem_in  = '0;
            dcnt_in = '0;
            state_in = (den_c == '0) ? S_OUT : S_DIV;
         end
         S_DIV: begin
            if (dcnt_ff == DC_W'(WS_W)) begin
               held_in  = neg_ff ? 16'(-pos_abs) : pos_abs;
               state_in = S_OUT;
            end else begin
               if (trial >= {1'b0, den_ff}) begin
                  rem_in = trial - {1'b0, den_ff};
                  quo_in = {quo_ff[WS_W-2:0], 1'b1};
               end else begin
                  rem_in = trial;
                  quo_in = {quo_ff[WS_W-2:0], 1'b0};
               end
               dcnt_in = dcnt_ff + DC_W'(1);
            end
         end
         S_OUT: begin
            if (!ovalid_ff || out_ready) begin
               ovalid_in = 1'b1;
               ostat_in  = status_ff;
               if (status_ff != ST_GOOD)
                  odata_in = {45'd0, held_ff};
               else if (cfg.analog)
                  odata_in = {peak_o, tot_sat, count_ff[3:0], mask_ff, lost_ff, held_ff};
               else
                  odata_in = {16'(count_ff != '0), 16'(count_ff), count_ff[3:0], mask_ff,
                              lost_ff, held_ff};
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   assign out_valid  = ovalid_ff;
   assign out_status = ostat_ff;
   assign out_data   = odata_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= S_IDLE;
         ovalid_ff <= 1'b0;
         held_ff   <= '0;
      end else begin
         state_ff  <= state_in;
         ovalid_ff <= ovalid_in;
         held_ff   <= held_in;
      end
      if (job_pop) begin
         for (int i = 0; i < CHANNELS; i++) samp_ff[i] <= job_samples[16*i +: 16];
      end
      status_ff <= status_in;
      k_ff      <= k_in;
      mask_ff   <= mask_in;
      count_ff  <= count_in;
      total_ff  <= total_in;
      peak_ff   <= peak_in;
      prod_ff   <= prod_in;
      wsum_ff   <= wsum_in;
      lost_ff   <= lost_in;
      neg_ff    <= neg_in;
      den_ff    <= den_in;
      rem_ff    <= rem_in;
      quo_ff    <= quo_in;
      dcnt_ff   <= dcnt_in;
      ostat_ff  <= ostat_in;
      odata_ff  <= odata_in;
   end

endmodule

>>> src/line_sensor_frame_centroid_core.sv
// Top level of the line sensor frame centroid core.
// Takes the reply bytes of a line sensor one beat at a time, finds 55 AA framed
// replies, checks command, length and inverted-sum checksum, and at each frame
// end returns one result beat: a status (good, bad, or length over limit as
// soon as the length byte arrives), the line position (held when the line is
// lost or the frame is bad), the black mask, the black count and the strengths.
// Bytes are accepted one per cycle while the two-entry job queue has room; any
// byte stalls while both entries are taken. A good frame passes through the
// engine's steps in order: taking the job, accumulation through one
// multiplier, setting up the divide, the bit-serial divider (skipped when the
// line is lost) and loading the result register; a bad frame goes from taking
// the job straight to the result register. Configuration writes are taken any
// cycle, one per beat.
module line_sensor_frame_centroid_core #(
   parameter int CHANNELS    = 8,
   parameter int MAX_PAYLOAD = 16
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [7:0]            req_tdata,   // rx_byte
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [63:0]           rsp_tdata,   // position, lost flag, mask of black
                                              // channels, black count, sample sum,
                                              // largest sample (both in analog mode), zero pad
   output lsfc_pkg::status_type  rsp_tuser,   // frame_status
   input  logic                  csr_we,
   input  lsfc_pkg::csr_addr_type csr_addr,
   input  logic [63:0]           csr_wdata
);
   import lsfc_pkg::*;

   localparam int JOB_W = 2 + CHANNELS * 16;

   cfg_type cfg_ff, cfg_in;

   logic                   q_full, q_nempty, q_pop, f_push;
   status_type             f_status;
   logic [CHANNELS*16-1:0] f_samples;
   logic [JOB_W-1:0]       q_out;
   logic [60:0]            b_data;

   // configuration registers
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         case (csr_addr)
            CSR_THRESHOLD: cfg_in.threshold = csr_wdata[15:0];
            CSR_BLACK_HI:  cfg_in.black_hi  = csr_wdata[0];
            CSR_REVERSE:   cfg_in.reverse   = csr_wdata[0];
            CSR_ANALOG:    cfg_in.analog    = csr_wdata[0];
            CSR_WEIGHTS_L: cfg_in.weights_l = csr_wdata;
            CSR_WEIGHTS_H: cfg_in.weights_h = csr_wdata;
            default:       cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.threshold <= 16'd2048;
         cfg_ff.black_hi  <= 1'b1;
         cfg_ff.reverse   <= 1'b0;
         cfg_ff.analog    <= 1'b1;
         cfg_ff.weights_l <= '0;
         cfg_ff.weights_h <= '0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // bytes stall only while the job queue holds two frames
   assign req_tready = ~q_full;

   lsfc_front #(.CHANNELS(CHANNELS), .MAX_PAYLOAD(MAX_PAYLOAD)) u_front (
      .clock       (clock),
      .reset       (reset),
      .byte_valid  (req_tvalid & req_tready),
      .byte_data   (req_tdata),
      .job_push    (f_push),
      .job_status  (f_status),
      .job_samples (f_samples)
   );

   lsfc_queue #(.WIDTH(JOB_W)) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (f_push),
      .push_data ({f_samples, f_status}),
      .full      (q_full),
      .pop       (q_pop),
      .not_empty (q_nempty),
      .pop_data  (q_out)
   );

   lsfc_back #(.CHANNELS(CHANNELS)) u_back (
      .clock       (clock),
      .reset       (reset),
      .cfg         (cfg_ff),
      .job_valid   (q_nempty),
      .job_status  (q_out[1:0]),
      .job_samples (q_out[JOB_W-1:2]),
      .job_pop     (q_pop),
      .out_valid   (rsp_tvalid),
      .out_ready   (rsp_tready),
      .out_status  (rsp_tuser),
      .out_data    (b_data)
   );

   assign rsp_tdata = {3'd0, b_data};

endmodule

>>> sim/tb_line_sensor_frame_centroid_core.sv
// Self-checking bench for the line sensor frame centroid core.
module tb_line_sensor_frame_centroid_core;
   timeunit 1ns;
   timeprecision 1ps;
   import lsfc_pkg::*;

   localparam int NCH        = 8;
   localparam int MAX_LEN    = 16;
   localparam int SETTLE     = 80;      // frame-end job queue plus divider latency
   localparam int CYCLE_CAP  = 600000;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [7:0]  req_tdata = '0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [63:0] rsp_tdata;
   status_type  rsp_tuser;
   logic        csr_we = 1'b0;
   csr_addr_type csr_addr = CSR_THRESHOLD;
   logic [63:0] csr_wdata = '0;

   line_sensor_frame_centroid_core #(.CHANNELS(NCH), .MAX_PAYLOAD(MAX_LEN)) DUT (.*);

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   typedef struct packed {
      status_type  status;
      logic [15:0] position;
      logic        lost;
      logic [7:0]  mask;
      logic [3:0]  count;
      logic [15:0] total;
      logic [15:0] peak;
   } centroid_rec_type;

   // Shadow configuration and parser state
   cfg_type     shadow_cfg;
   logic [4:0]  parse_offset;
   logic [7:0]  frame_bytes [0:MAX_LEN+4];
   logic [15:0] held_pos;

   centroid_rec_type frame_results_q[$];
   int mismatches = 0;
   int cycle_count = 0;

   function automatic logic signed [15:0] chan_weight(int ch);
      if (ch < 4) return shadow_cfg.weights_l[16*ch +: 16];
      return shadow_cfg.weights_h[16*(ch-4) +: 16];
   endfunction

   // Evaluate a completed frame held in frame_bytes
   function automatic centroid_rec_type evaluate_frame();
      centroid_rec_type r;
      logic [7:0]  sum;
      logic [15:0] samp [NCH];
      int unsigned len, total, peak, count;
      longint wsum;
      int mwsum, lg;
      r = '0;
      len = frame_bytes[3];
      sum = 8'd0;
      for (int i = 2; i < 4 + len; i++) sum += frame_bytes[i];
      if (frame_bytes[2] != CMD_ANALOG || len != 2*NCH || ~sum != frame_bytes[4+len]) begin
         r.status = ST_BAD;
         r.position = held_pos;
         return r;
      end
      for (int i = 0; i < NCH; i++) begin
         lg = shadow_cfg.reverse ? NCH - 1 - i : i;
         samp[lg] = {frame_bytes[5+2*i], frame_bytes[4+2*i]};
      end
      count = 0;
      for (int i = 0; i < NCH; i++)
         if (shadow_cfg.black_hi ? samp[i] > shadow_cfg.threshold
                                 : samp[i] < shadow_cfg.threshold) begin
            r.mask[i] = 1'b1;
            count++;
         end
      r.count = 4'(count);
      if (shadow_cfg.analog) begin
         total = 0; peak = 0; wsum = 0;
         for (int i = 0; i < NCH; i++) begin
            total += samp[i];
            wsum += longint'(chan_weight(i)) * longint'(samp[i]);
            if (samp[i] > peak) peak = samp[i];
         end
         r.lost = (total == 0);
         if (!r.lost) held_pos = 16'(wsum / longint'(total));
         r.total = (total > 65535) ? 16'hFFFF : 16'(total);
         r.peak = 16'(peak);
      end else begin
         mwsum = 0;
         for (int i = 0; i < NCH; i++)
            if (r.mask[i]) mwsum += int'(chan_weight(i));
         r.total = 16'(count);
         r.peak = (count != 0) ? 16'd1 : 16'd0;
         r.lost = (count == 0);
         if (!r.lost) held_pos = 16'(mwsum / int'(count));
      end
      r.status = ST_GOOD;
      r.position = held_pos;
      return r;
   endfunction

   // Advance the shadow parser by one byte; returns 1 when a result is due
   function automatic bit parse_byte(logic [7:0] b, output centroid_rec_type r);
      r = '0;
      if (parse_offset == 5'd0) begin
         if (b == HDR_FIRST) parse_offset = 5'd1;
         return 0;
      end
      if (parse_offset == 5'd1) begin
         if (b == HDR_SECOND) parse_offset = 5'd2;
         else if (b != HDR_FIRST) parse_offset = 5'd0;
         return 0;
      end
      frame_bytes[parse_offset] = b;
      parse_offset++;
      if (parse_offset == 4 && frame_bytes[3] > MAX_LEN) begin
         parse_offset = 5'd0;
         r.status = ST_OVER;
         r.position = held_pos;
         return 1;
      end
      if (parse_offset >= 4 && parse_offset == 5 + frame_bytes[3]) begin
         parse_offset = 5'd0;
         r = evaluate_frame();
         return 1;
      end
      return 0;
   endfunction

   // Sender: bursts of random length with random gaps
   int burst_left = 0;

   task automatic send_byte(logic [7:0] b, bit typed = 0, centroid_rec_type typed_rec = '0);
      centroid_rec_type r;
      int gap;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 40);
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
         if (gap != 0) begin
            req_tvalid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
      req_tvalid <= 1'b1;
      req_tdata  <= b;
      // tready is sampled before the block's own updates of this edge
      do @(posedge clock); while (!req_tready);
      burst_left--;
      if (parse_byte(b, r)) frame_results_q.push_back(typed ? typed_rec : r);
   endtask

   task automatic drain_and_settle();
      req_tvalid <= 1'b0;
      burst_left = 0;
      @(posedge clock);
      while (frame_results_q.size() != 0) @(posedge clock);
      repeat (SETTLE) @(posedge clock);
   endtask

   // leaves csr_we high; the caller drops it after the last write
   task automatic write_csr(csr_addr_type a, logic [63:0] d);
      csr_we    <= 1'b1;
      csr_addr  <= a;
      csr_wdata <= d;
      @(posedge clock);
      case (a)
         CSR_THRESHOLD: shadow_cfg.threshold = d[15:0];
         CSR_BLACK_HI:  shadow_cfg.black_hi  = d[0];
         CSR_REVERSE:   shadow_cfg.reverse   = d[0];
         CSR_ANALOG:    shadow_cfg.analog    = d[0];
         CSR_WEIGHTS_L: shadow_cfg.weights_l = d;
         CSR_WEIGHTS_H: shadow_cfg.weights_h = d;
         default: ;
      endcase
   endtask

   function automatic logic [15:0] pick_sample(int style);
      case (style)
         0: return 16'($urandom);
         1: return 16'd0;
         2: return 16'hFFFF;
         3: return shadow_cfg.threshold + 16'($urandom_range(0, 4)) - 16'd2;
         default: return $urandom_range(0, 1) ? 16'hFFFF : 16'd0;
      endcase
   endfunction

   // One sensor reply; mostly well-formed, sometimes with a broken field
   task automatic send_frame();
      logic [7:0] body [$];
      logic [7:0] sum;
      logic [15:0] s;
      int flaw, len, style;
      flaw  = $urandom_range(0, 9);   // 0..5 clean, others broken
      style = $urandom_range(0, 5);
      len   = (flaw == 7) ? $urandom_range(0, MAX_LEN) : 2*NCH;
      if (flaw == 8) len = $urandom_range(MAX_LEN + 1, 255);
      body.push_back((flaw == 6) ? 8'($urandom) : CMD_ANALOG);
      body.push_back(8'(len));
      if (len <= MAX_LEN)
         for (int i = 0; i < len; i += 2) begin
            s = pick_sample(style == 5 ? $urandom_range(0, 4) : style);
            body.push_back(s[7:0]);
            if (i + 1 < len) body.push_back(s[15:8]);
         end
      sum = 8'd0;
      foreach (body[i]) sum += body[i];
      if (len <= MAX_LEN) body.push_back((flaw == 9) ? ~sum ^ 8'(1 << $urandom_range(0, 7)) : ~sum);
      if ($urandom_range(0, 7) == 0) send_byte(HDR_FIRST);   // repeated header byte
      send_byte(HDR_FIRST);
      send_byte(HDR_SECOND);
      foreach (body[i]) send_byte(body[i]);
   endtask

   // Directed rows: parser corners, typed where the outcome is obvious
   typedef struct {
      logic [7:0] b;
      bit         typed;
      status_type st;
   } dir_row_type;

   dir_row_type dir_rows[] = '{
      '{8'h00, 0, ST_GOOD}, '{8'hAA, 0, ST_GOOD}, '{8'h55, 0, ST_GOOD},
      '{8'h13, 0, ST_GOOD},                          // stray byte back to hunting
      '{8'h55, 0, ST_GOOD}, '{8'h55, 0, ST_GOOD},    // repeated 55 keeps waiting
      '{8'hAA, 0, ST_GOOD}, '{8'h02, 0, ST_GOOD},
      '{8'hFF, 1, ST_OVER},                          // length 255 dropped at once
      '{8'h55, 0, ST_GOOD}, '{8'hAA, 0, ST_GOOD}, '{8'h02, 0, ST_GOOD},
      '{8'h11, 1, ST_OVER},                          // one above the limit
      '{8'h55, 0, ST_GOOD}, '{8'hAA, 0, ST_GOOD}, '{8'h02, 0, ST_GOOD},
      '{8'h00, 0, ST_GOOD}, '{8'hFD, 1, ST_BAD}      // empty payload, good sum
   };

   // Receiver: stall percentage redrawn from 0, 30, 70 and 95
   int stall_pct = 0;

   always @(posedge clock) begin
      centroid_rec_type got, want;
      cycle_count <= cycle_count + 1;
      if (cycle_count % 200 == 0) begin
         case ($urandom_range(0, 3))
            0: stall_pct = 0;
            1: stall_pct = 30;
            2: stall_pct = 70;
            default: stall_pct = 95;
         endcase
      end
      if (!reset && rsp_tvalid && rsp_tready) begin
         got = '{rsp_tuser, rsp_tdata[15:0], rsp_tdata[16], rsp_tdata[24:17],
                 rsp_tdata[28:25], rsp_tdata[44:29], rsp_tdata[60:45]};
         if (frame_results_q.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("unexpected result beat %p", got);
         end else begin
            want = frame_results_q.pop_front();
            if (got.status !== want.status || got.position !== want.position ||
                got.lost !== want.lost || got.mask !== want.mask ||
                got.count !== want.count || got.total !== want.total ||
                got.peak !== want.peak) begin
               mismatches++;
               if (mismatches <= 10) $display("mismatch: exp %p got %p", want, got);
            end
         end
      end
      rsp_tready <= ($urandom_range(0, 99) >= stall_pct);
      if (cycle_count >= CYCLE_CAP) begin
         $display("Regression FAIL");
         $finish;
      end
   end

   initial begin
      centroid_rec_type tr;
      shadow_cfg   = '{16'd2048, 1'b1, 1'b0, 1'b1, 64'd0, 64'd0};
      parse_offset = 5'd0;
      held_pos     = 16'd0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (dir_rows[i]) begin
         tr = '0;
         tr.status = dir_rows[i].st;
         send_byte(dir_rows[i].b, dir_rows[i].typed, tr);
      end

      // Phases of configuration; after the reset settings, two phases hit the extremes
      for (int ph = 0; ph < 7; ph++) begin
         drain_and_settle();
         case (ph)
            0: ;   // reset settings
            1: begin
               write_csr(CSR_THRESHOLD, 64'd0);
               write_csr(CSR_BLACK_HI, 64'd1);
               write_csr(CSR_REVERSE, 64'd0);
               write_csr(CSR_ANALOG, 64'd1);
               write_csr(CSR_WEIGHTS_L, 64'h7FFF_7FFF_7FFF_7FFF);
               write_csr(CSR_WEIGHTS_H, 64'h8000_8000_8000_8000);
            end
            2: begin
               write_csr(CSR_THRESHOLD, 64'hFFFF);
               write_csr(CSR_BLACK_HI, 64'd0);
               write_csr(CSR_REVERSE, 64'd1);
               write_csr(CSR_ANALOG, 64'd0);
               write_csr(CSR_WEIGHTS_L, 64'h8000_8000_8000_8000);
               write_csr(CSR_WEIGHTS_H, 64'h7FFF_7FFF_7FFF_7FFF);
            end
            default: begin
               write_csr(CSR_THRESHOLD, 64'($urandom));
               write_csr(CSR_BLACK_HI, 64'($urandom_range(0, 1)));
               write_csr(CSR_REVERSE, 64'($urandom_range(0, 1)));
               write_csr(CSR_ANALOG, 64'($urandom_range(0, 1)));
               write_csr(CSR_WEIGHTS_L, {$urandom, $urandom});
               write_csr(CSR_WEIGHTS_H, {$urandom, $urandom});
            end
         endcase
         csr_we <= 1'b0;
         for (int n = 0; n < 90; ) begin
            if ($urandom_range(0, 9) == 0) begin
               send_byte(8'($urandom));   // line noise
               n++;
            end else begin
               send_frame();
               n += 21;
            end
         end
      end

      drain_and_settle();
      if (mismatches == 0 && frame_results_q.size() == 0)
         $display("Regression PASS");
      else
         $display("Regression FAIL");
      $finish;
   end

endmodule
